// ----- rtl/core/packet_record_widening_converter_core_assert.svh -----
// Assertion macros for the packet record widening converter core.
// Included inside module bodies; relies only on the clock and reset names passed in.
`ifndef PACKET_RECORD_WIDENING_CONVERTER_CORE_ASSERT_SVH
`define PACKET_RECORD_WIDENING_CONVERTER_CORE_ASSERT_SVH

// same-cycle implication under reset
`define PRWC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define PRWC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/prwc_pkg.sv -----
// Package for the packet record widening converter: codes, constants and sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package prwc_pkg;

    localparam int unsigned BUFFER_BYTES = 65536;
    localparam int unsigned ADDR_W       = $clog2(BUFFER_BYTES);
    localparam int unsigned CNT_W        = ADDR_W + 1;

    localparam logic [1:0] FN_CLEAR  = 2'd0;
    localparam logic [1:0] FN_APPEND = 2'd1;
    localparam logic [1:0] FN_EVAL   = 2'd2;
    localparam logic [1:0] FN_READ   = 2'd3;

    localparam logic [1:0] ST_CONV = 2'd0;
    localparam logic [1:0] ST_SAME = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;
    localparam logic [1:0] ST_CAP  = 2'd3;

    localparam logic [2:0] LK_NONE      = 3'd0;
    localparam logic [2:0] LK_ROWS_FF   = 3'd1;
    localparam logic [2:0] LK_ROWS_ZERO = 3'd2;
    localparam logic [2:0] LK_TAIL      = 3'd3;
    localparam logic [2:0] LK_INSERT    = 3'd4;
    localparam logic [2:0] LK_TRIPLE    = 3'd5;

    localparam logic [7:0] OP_ROWS_A = 8'h1b;
    localparam logic [7:0] OP_ROWS_B = 8'h27;
    localparam logic [7:0] OP_PLAIN  = 8'h58;
    localparam logic [7:0] OP_TEXT   = 8'h91;
    localparam logic [7:0] OP_EXT    = 8'hfe;
    localparam logic [7:0] OP_TRIPLE = 8'hb5;

    localparam logic [15:0] SUB_TAIL2  = 16'h0013;
    localparam logic [15:0] SUB_TAIL1A = 16'h0015;
    localparam logic [15:0] SUB_TAIL1B = 16'h0016;
    localparam logic [15:0] SUB_ROWS   = 16'h0017;
    localparam logic [15:0] SUB_INSERT = 16'h0018;

    localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(65533);
    localparam logic [7:0]       FILL_FF = 8'hff;

    typedef enum logic [4:0] {
        S_IDLE,
        S_EXEC,
        S_FA,
        S_FB,
        S_EV_OP,
        S_EV_SUB,
        S_EV_CNT16,
        S_EV_HEAD,
        S_EV_CNT32,
        S_SCAN,
        S_SCAN_CHK,
        S_B5,
        S_X18_A,
        S_X18_B,
        S_X18_C,
        S_MUL_OLD,
        S_CHK_OLD,
        S_MUL_NEW,
        S_CHK_NEW,
        S_DIV,
        S_RD_MUL,
        S_RD_ADDR,
        S_RD_TAKE,
        S_DONE
    } state_t;

endpackage

// ----- rtl/core/packet_record_widening_converter_core.sv -----
// Packet record widening converter core: packet store, evaluate sequencer and read path.
// Depends on prwc_pkg and packet_record_widening_converter_core_assert.svh.
`timescale 1ns / 1ps

// One word is taken at a time; in_ready is high only while the sequencer is idle, and the
// finished result sits in an output register so the next word can be taken while it waits.
// Every memory byte is fetched through the single store read port. A read of a widened-row
// byte passes through the one-bit divider, one shared multiply and one store fetch.
// Evaluate fetches up to 8 bytes of count fields, scans string pairs, and for row layouts
// uses the shared multiplier and range checks. Bytes never appended are never read.
module packet_record_widening_converter_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   func,
    input  logic [7:0]                   data_byte,
    input  logic [15:0]                  out_index,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   status,
    output logic [15:0]                  out_length,
    output logic [7:0]                   out_byte,
    input  logic                         cfg_wr_en,
    input  logic [15:0]                  cfg_wr_data
);
    import prwc_pkg::*;

    `include "packet_record_widening_converter_core_assert.svh"

    logic [7:0] mem [BUFFER_BYTES];

    state_t              state_reg, state_next;
    state_t              ret_reg, ret_next;
    logic [1:0]          func_reg, func_next;
    logic [7:0]          db_reg, db_next;
    logic [15:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                ovf_reg, ovf_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [31:0]         acc_reg, acc_next;
    logic [2:0]          left_reg, left_next;
    logic [7:0]          rd_data_reg;
    logic [7:0]          op_reg, op_next;
    logic [CNT_W-1:0]    head_reg, head_next;
    logic [5:0]          oldr_reg, oldr_next;
    logic [5:0]          newr_reg, newr_next;
    logic [2:0]          kind_reg, kind_next;
    logic [31:0]         count_reg, count_next;
    logic [37:0]         prod_reg, prod_next;
    logic [CNT_W-1:0]    oldsz_reg, oldsz_next;
    logic [1:0]          lat_status_reg, lat_status_next;
    logic [CNT_W-1:0]    lat_len_reg, lat_len_next;
    logic [2:0]          lat_kind_reg, lat_kind_next;
    logic [CNT_W-1:0]    lat_hdr_reg, lat_hdr_next;
    logic [5:0]          lat_oldr_reg, lat_oldr_next;
    logic [5:0]          lat_newr_reg, lat_newr_next;
    logic [15:0]         div_q_reg, div_q_next;
    logic [5:0]          div_rem_reg, div_rem_next;
    logic [3:0]          div_cnt_reg, div_cnt_next;
    logic [7:0]          res_reg, res_next;
    logic                out_valid_reg, out_valid_next;
    logic [1:0]          out_status_reg, out_status_next;
    logic [15:0]         out_len_reg, out_len_next;
    logic [7:0]          out_byte_reg, out_byte_next;
    logic [15:0]         cap_reg;

    logic                mem_we;
    logic [31:0]         mul_a;
    logic [5:0]          mul_b;
    logic [37:0]         mul_p;
    logic [37:0]         sum38;
    logic [6:0]          trial;
    logic [CNT_W-1:0]    n;
    logic [CNT_W-1:0]    tmp17;
    logic [CNT_W-1:0]    olds, extra;
    logic [15:0]         sub;
    logic [16:0]         i17;
    logic [16:0]         jt;

    function automatic logic over_cap(input logic [37:0] size, input logic [15:0] cap);
        over_cap = (size > {22'd0, cap}) || (size > {21'd0, MAX_LEN});
    endfunction

    assign n         = cnt_reg;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign out_length = out_len_reg;
    assign out_byte  = out_byte_reg;

    // shared multiplier: record count by row length, or row number by old row length
    assign mul_p = mul_a * {26'd0, mul_b};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cnt_reg[ADDR_W-1:0]] <= db_reg;
        end
        rd_data_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            cnt_reg        <= '0;
            ovf_reg        <= 1'b0;
            lat_status_reg <= ST_SAME;
            lat_len_reg    <= '0;
            lat_kind_reg   <= LK_NONE;
            lat_hdr_reg    <= '0;
            lat_oldr_reg   <= '0;
            lat_newr_reg   <= '0;
            out_valid_reg  <= 1'b0;
            cap_reg        <= 16'hffff;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            cnt_reg        <= cnt_next;
            ovf_reg        <= ovf_next;
            lat_status_reg <= lat_status_next;
            lat_len_reg    <= lat_len_next;
            lat_kind_reg   <= lat_kind_next;
            lat_hdr_reg    <= lat_hdr_next;
            lat_oldr_reg   <= lat_oldr_next;
            lat_newr_reg   <= lat_newr_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        db_reg         <= db_next;
        idx_reg        <= idx_next;
        addr_reg       <= addr_next;
        acc_reg        <= acc_next;
        left_reg       <= left_next;
        op_reg         <= op_next;
        head_reg       <= head_next;
        oldr_reg       <= oldr_next;
        newr_reg       <= newr_next;
        kind_reg       <= kind_next;
        count_reg      <= count_next;
        prod_reg       <= prod_next;
        oldsz_reg      <= oldsz_next;
        div_q_reg      <= div_q_next;
        div_rem_reg    <= div_rem_next;
        div_cnt_reg    <= div_cnt_next;
        res_reg        <= res_next;
        out_status_reg <= out_status_next;
        out_len_reg    <= out_len_next;
        out_byte_reg   <= out_byte_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        func_next       = func_reg;
        db_next         = db_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        ovf_next        = ovf_reg;
        addr_next       = addr_reg;
        acc_next        = acc_reg;
        left_next       = left_reg;
        op_next         = op_reg;
        head_next       = head_reg;
        oldr_next       = oldr_reg;
        newr_next       = newr_reg;
        kind_next       = kind_reg;
        count_next      = count_reg;
        prod_next       = prod_reg;
        oldsz_next      = oldsz_reg;
        lat_status_next = lat_status_reg;
        lat_len_next    = lat_len_reg;
        lat_kind_next   = lat_kind_reg;
        lat_hdr_next    = lat_hdr_reg;
        lat_oldr_next   = lat_oldr_reg;
        lat_newr_next   = lat_newr_reg;
        div_q_next      = div_q_reg;
        div_rem_next    = div_rem_reg;
        div_cnt_next    = div_cnt_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_len_next    = out_len_reg;
        out_byte_next   = out_byte_reg;
        mem_we          = 1'b0;
        mul_a           = count_reg;
        mul_b           = oldr_reg;
        sum38           = prod_reg + {21'd0, head_reg};
        trial           = {div_rem_reg, div_q_reg[15]};
        tmp17           = '0;
        olds            = '0;
        extra           = '0;
        sub             = acc_reg[31:16];
        i17             = {1'b0, idx_reg};
        jt              = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next  = func;
                    db_next    = data_byte;
                    idx_next   = out_index;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_next   = 8'd0;
                state_next = S_DONE;
                if (func_reg != FN_READ)
                begin
                    // every other command drops the previous result first
                    lat_status_next = ST_SAME;
                    lat_len_next    = '0;
                    lat_kind_next   = LK_NONE;
                    lat_hdr_next    = '0;
                    lat_oldr_next   = '0;
                    lat_newr_next   = '0;
                end
                case (func_reg)
                    FN_CLEAR:
                    begin
                        cnt_next = '0;
                        ovf_next = 1'b0;
                    end
                    FN_APPEND:
                    begin
                        if (cnt_reg < CNT_W'(BUFFER_BYTES))
                        begin
                            mem_we   = 1'b1;
                            cnt_next = cnt_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    FN_EVAL:
                    begin
                        if (ovf_reg || (n == '0) || (n > MAX_LEN))
                        begin
                            lat_status_next = ST_BAD;
                        end
                        else
                        begin
                            addr_next  = '0;
                            left_next  = 3'd1;
                            ret_next   = S_EV_OP;
                            state_next = S_FA;
                        end
                    end
                    default:
                    begin
                        if ((lat_status_reg == ST_CONV) && (i17 < lat_len_reg))
                        begin
                            left_next = 3'd1;
                            ret_next  = S_RD_TAKE;
                            case (lat_kind_reg)
                                LK_ROWS_FF, LK_ROWS_ZERO:
                                begin
                                    if (i17 < lat_hdr_reg)
                                    begin
                                        addr_next  = idx_reg;
                                        state_next = S_FA;
                                    end
                                    else
                                    begin
                                        tmp17        = i17 - lat_hdr_reg;
                                        div_q_next   = tmp17[15:0];
                                        div_rem_next = '0;
                                        div_cnt_next = '0;
                                        state_next   = S_DIV;
                                    end
                                end
                                LK_TAIL:
                                begin
                                    if (i17 < n)
                                    begin
                                        addr_next  = idx_reg;
                                        state_next = S_FA;
                                    end
                                end
                                LK_INSERT:
                                begin
                                    if (idx_reg < 16'd19)
                                    begin
                                        addr_next  = idx_reg;
                                        state_next = S_FA;
                                    end
                                    else if (idx_reg >= 16'd23)
                                    begin
                                        addr_next  = idx_reg - 16'd4;
                                        state_next = S_FA;
                                    end
                                end
                                LK_TRIPLE:
                                begin
                                    tmp17 = lat_hdr_reg + 17'd28;
                                    if (i17 < tmp17)
                                    begin
                                        addr_next  = idx_reg;
                                        state_next = S_FA;
                                    end
                                    else
                                    begin
                                        jt = i17 - tmp17;
                                        // upper half of each widened qword is zero
                                        if (!jt[2])
                                        begin
                                            tmp17 = tmp17 + {jt[16:3], 2'b00} + {15'd0, jt[1:0]};
                                            addr_next  = tmp17[ADDR_W-1:0];
                                            state_next = S_FA;
                                        end
                                    end
                                end
                                default:
                                begin
                                    state_next = S_DONE;
                                end
                            endcase
                        end
                    end
                endcase
            end

            S_FA:
            begin
                state_next = S_FB;
            end

            S_FB:
            begin
                // little-endian gather: newest byte enters at the top
                acc_next  = {rd_data_reg, acc_reg[31:8]};
                addr_next = addr_reg + 1'b1;
                left_next = left_reg - 1'b1;
                state_next = (left_reg == 3'd1) ? ret_reg : S_FA;
            end

            S_EV_OP:
            begin
                op_next    = acc_reg[31:24];
                state_next = S_DONE;
                case (acc_reg[31:24])
                    OP_ROWS_A, OP_ROWS_B:
                    begin
                        kind_next = LK_ROWS_FF;
                        if (acc_reg[31:24] == OP_ROWS_A)
                        begin
                            head_next = CNT_W'(5);
                            oldr_next = 6'd28;
                            newr_next = 6'd36;
                        end
                        else
                        begin
                            head_next = CNT_W'(3);
                            oldr_next = 6'd30;
                            newr_next = 6'd38;
                        end
                        tmp17 = (acc_reg[31:24] == OP_ROWS_A) ? CNT_W'(5) : CNT_W'(3);
                        if (n < tmp17)
                        begin
                            lat_status_next = ST_BAD;
                        end
                        else
                        begin
                            tmp17      = tmp17 - CNT_W'(2);
                            addr_next  = tmp17[ADDR_W-1:0];
                            left_next  = 3'd2;
                            ret_next   = S_EV_CNT16;
                            state_next = S_FA;
                        end
                    end
                    OP_PLAIN, OP_TEXT:
                    begin
                        head_next  = CNT_W'(1);
                        oldr_next  = 6'd12;
                        newr_next  = 6'd13;
                        kind_next  = LK_ROWS_ZERO;
                        state_next = (acc_reg[31:24] == OP_TEXT) ? S_SCAN : S_EV_HEAD;
                    end
                    OP_EXT:
                    begin
                        if (n < CNT_W'(3))
                        begin
                            lat_status_next = ST_BAD;
                        end
                        else
                        begin
                            addr_next  = ADDR_W'(1);
                            left_next  = 3'd2;
                            ret_next   = S_EV_SUB;
                            state_next = S_FA;
                        end
                    end
                    OP_TRIPLE:
                    begin
                        head_next  = CNT_W'(21);
                        state_next = S_SCAN;
                    end
                    default:
                    begin
                        lat_status_next = ST_SAME;
                    end
                endcase
            end

            S_EV_CNT16:
            begin
                count_next = {16'd0, acc_reg[31:16]};
                state_next = S_MUL_OLD;
            end

            S_SCAN:
            begin
                if ((head_reg + 1'b1) < n)
                begin
                    addr_next  = head_reg[ADDR_W-1:0];
                    left_next  = 3'd2;
                    ret_next   = S_SCAN_CHK;
                    state_next = S_FA;
                end
                else
                begin
                    lat_status_next = ST_BAD;
                    state_next      = S_DONE;
                end
            end

            S_SCAN_CHK:
            begin
                head_next = head_reg + CNT_W'(2);
                if (acc_reg[31:16] == 16'd0)
                begin
                    state_next = (op_reg == OP_TEXT) ? S_EV_HEAD : S_B5;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end

            S_EV_HEAD:
            begin
                if (n < (head_reg + CNT_W'(4)))
                begin
                    lat_status_next = ST_BAD;
                    state_next      = S_DONE;
                end
                else
                begin
                    addr_next  = head_reg[ADDR_W-1:0];
                    head_next  = head_reg + CNT_W'(4);
                    left_next  = 3'd4;
                    ret_next   = S_EV_CNT32;
                    state_next = S_FA;
                end
            end

            S_EV_CNT32:
            begin
                count_next = acc_reg;
                state_next = S_MUL_OLD;
            end

            S_EV_SUB:
            begin
                head_next  = CNT_W'(3);
                state_next = S_DONE;
                case (sub)
                    SUB_TAIL2, SUB_TAIL1A, SUB_TAIL1B:
                    begin
                        if (sub == SUB_TAIL2)
                        begin
                            olds  = CNT_W'(23);
                            extra = CNT_W'(2);
                        end
                        else
                        begin
                            olds  = (sub == SUB_TAIL1A) ? CNT_W'(17) : CNT_W'(22);
                            extra = CNT_W'(1);
                        end
                        tmp17 = n + extra;
                        if (n == (olds + extra))
                        begin
                            lat_status_next = ST_SAME;
                        end
                        else if (n != olds)
                        begin
                            lat_status_next = ST_BAD;
                        end
                        else if (over_cap({21'd0, tmp17}, cap_reg))
                        begin
                            lat_status_next = ST_CAP;
                        end
                        else
                        begin
                            lat_status_next = ST_CONV;
                            lat_kind_next   = LK_TAIL;
                            lat_len_next    = tmp17;
                        end
                    end
                    SUB_INSERT:
                    begin
                        tmp17 = n - CNT_W'(31);
                        if ((n >= CNT_W'(31)) && (tmp17[3:0] == 4'd0))
                        begin
                            addr_next  = ADDR_W'(27);
                            left_next  = 3'd4;
                            ret_next   = S_X18_A;
                            state_next = S_FA;
                        end
                        else
                        begin
                            state_next = S_X18_B;
                        end
                    end
                    SUB_ROWS:
                    begin
                        oldr_next  = 6'd16;
                        newr_next  = 6'd20;
                        kind_next  = LK_ROWS_ZERO;
                        state_next = S_EV_HEAD;
                    end
                    default:
                    begin
                        lat_status_next = ST_SAME;
                    end
                endcase
            end

            S_X18_A:
            begin
                tmp17 = n - CNT_W'(31);
                if (acc_reg == {19'd0, tmp17[16:4]})
                begin
                    lat_status_next = ST_SAME;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_X18_B;
                end
            end

            S_X18_B:
            begin
                tmp17 = n - CNT_W'(27);
                if ((n < CNT_W'(27)) || (tmp17[3:0] != 4'd0))
                begin
                    lat_status_next = ST_BAD;
                    state_next      = S_DONE;
                end
                else
                begin
                    addr_next  = ADDR_W'(23);
                    left_next  = 3'd4;
                    ret_next   = S_X18_C;
                    state_next = S_FA;
                end
            end

            S_X18_C:
            begin
                tmp17      = n - CNT_W'(27);
                state_next = S_DONE;
                if (acc_reg != {19'd0, tmp17[16:4]})
                begin
                    lat_status_next = ST_BAD;
                end
                else if (over_cap({21'd0, n} + 38'd4, cap_reg))
                begin
                    lat_status_next = ST_CAP;
                end
                else
                begin
                    lat_status_next = ST_CONV;
                    lat_kind_next   = LK_INSERT;
                    lat_len_next    = n + CNT_W'(4);
                end
            end

            S_B5:
            begin
                state_next = S_DONE;
                if ({1'b0, n} == ({1'b0, head_reg} + 18'd52))
                begin
                    lat_status_next = ST_SAME;
                end
                else if ({1'b0, n} != ({1'b0, head_reg} + 18'd40))
                begin
                    lat_status_next = ST_BAD;
                end
                else if (over_cap({21'd0, n} + 38'd12, cap_reg))
                begin
                    lat_status_next = ST_CAP;
                end
                else
                begin
                    lat_status_next = ST_CONV;
                    lat_kind_next   = LK_TRIPLE;
                    lat_hdr_next    = head_reg;
                    lat_len_next    = n + CNT_W'(12);
                end
            end

            S_MUL_OLD:
            begin
                mul_b      = oldr_reg;
                prod_next  = mul_p;
                state_next = S_CHK_OLD;
            end

            S_CHK_OLD:
            begin
                // too many records for the old layout to fit at all
                if (sum38 > {21'd0, MAX_LEN})
                begin
                    lat_status_next = ST_BAD;
                    state_next      = S_DONE;
                end
                else
                begin
                    oldsz_next = sum38[CNT_W-1:0];
                    state_next = S_MUL_NEW;
                end
            end

            S_MUL_NEW:
            begin
                mul_b      = newr_reg;
                prod_next  = mul_p;
                state_next = S_CHK_NEW;
            end

            S_CHK_NEW:
            begin
                state_next = S_DONE;
                if ({21'd0, n} == sum38)
                begin
                    lat_status_next = ST_SAME;
                end
                else if (n != oldsz_reg)
                begin
                    lat_status_next = ST_BAD;
                end
                else if (over_cap(sum38, cap_reg))
                begin
                    lat_status_next = ST_CAP;
                end
                else
                begin
                    lat_status_next = ST_CONV;
                    lat_kind_next   = kind_reg;
                    lat_hdr_next    = head_reg;
                    lat_oldr_next   = oldr_reg;
                    lat_newr_next   = newr_reg;
                    lat_len_next    = sum38[CNT_W-1:0];
                end
            end

            S_DIV:
            begin
                // restoring divide, one quotient bit a cycle
                if (trial >= {1'b0, lat_newr_reg})
                begin
                    trial        = trial - {1'b0, lat_newr_reg};
                    div_q_next   = {div_q_reg[14:0], 1'b1};
                end
                else
                begin
                    div_q_next   = {div_q_reg[14:0], 1'b0};
                end
                div_rem_next = trial[5:0];
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == 4'd15)
                begin
                    state_next = S_RD_MUL;
                end
            end

            S_RD_MUL:
            begin
                mul_a      = {16'd0, div_q_reg};
                mul_b      = lat_oldr_reg;
                prod_next  = mul_p;
                state_next = S_RD_ADDR;
            end

            S_RD_ADDR:
            begin
                if (div_rem_reg < lat_oldr_reg)
                begin
                    sum38      = prod_reg + {21'd0, lat_hdr_reg} + {32'd0, div_rem_reg};
                    addr_next  = sum38[ADDR_W-1:0];
                    left_next  = 3'd1;
                    ret_next   = S_RD_TAKE;
                    state_next = S_FA;
                end
                else
                begin
                    if ((lat_kind_reg == LK_ROWS_FF) &&
                        ((div_rem_reg - lat_oldr_reg) >= 6'd4))
                    begin
                        res_next = FILL_FF;
                    end
                    else
                    begin
                        res_next = 8'd0;
                    end
                    state_next = S_DONE;
                end
            end

            S_RD_TAKE:
            begin
                res_next   = acc_reg[31:24];
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = lat_status_reg;
                    out_len_next    = (lat_status_reg == ST_CONV) ? lat_len_reg[15:0] : 16'd0;
                    out_byte_next   = res_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `PRWC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "accepted word must leave the sequencer busy")
    `PRWC_ASSERT_NOW(a_len_zero_unless_conv, clk, rst_n, lat_status_reg != ST_CONV, lat_len_reg == '0, "latched length set without a converted status")
    `PRWC_ASSERT_NOW(a_conv_len_bound, clk, rst_n, lat_status_reg == ST_CONV, lat_len_reg <= MAX_LEN, "converted length beyond the maximum")
    `PRWC_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(BUFFER_BYTES), "byte count beyond the store")

endmodule

// ----- tb/tb_packet_record_widening_converter_core.sv -----
// Testbench for packet_record_widening_converter_core: builds packets of every layout,
// predicts each result in a local model and checks the output words in order.
// Depends on prwc_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_packet_record_widening_converter_core;
    import prwc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2000000;

    typedef struct {
        bit          is_cfg;
        bit          fast;
        logic [1:0]  fn;
        logic [7:0]  db;
        logic [15:0] idx;
        logic [15:0] cfgv;
    } stim_t;

    typedef struct {
        logic [1:0]  st;
        logic [15:0] len;
        logic [7:0]  ob;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  func;
    logic [7:0]  data_byte;
    logic [15:0] out_index;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [15:0] out_length;
    logic [7:0]  out_byte;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    stim_t       pending_words[$];
    result_t     expected_results[$];
    int unsigned n_issued;
    int unsigned n_acc;
    int unsigned n_out;
    int unsigned n_fail;
    int unsigned cycles;
    bit          burst_mode;

    // widening model state
    logic [7:0]  pkt_mem [0:BUFFER_BYTES-1];
    int unsigned m_cnt, m_head, m_recs, m_oldr, m_newr, m_len, m_cap;
    bit          m_ovf;
    logic [2:0]  m_kind;
    logic [1:0]  m_stat;

    packet_record_widening_converter_core dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .data_byte   (data_byte),
        .out_index   (out_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .out_length  (out_length),
        .out_byte    (out_byte),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned fetch(int unsigned i);
        return (i < BUFFER_BYTES) ? int'(pkt_mem[i]) : 0;
    endfunction

    function automatic int unsigned dword_at(int unsigned i);
        return fetch(i) | (fetch(i + 1) << 8) | (fetch(i + 2) << 16) | (fetch(i + 3) << 24);
    endfunction

    // position just past an aligned double zero, 0 if the string never ends
    function automatic int unsigned string_end(int unsigned n, int unsigned from);
        int unsigned i;
        i = from;
        while (i + 1 < n)
        begin
            if (fetch(i) == 0 && fetch(i + 1) == 0)
                return i + 2;
            i += 2;
        end
        return 0;
    endfunction

    function automatic logic [1:0] fit_code(int unsigned tot);
        return (tot > m_cap || tot > 65533) ? ST_CAP : ST_CONV;
    endfunction

    function automatic void forget_layout();
        m_stat = ST_SAME;
        m_len  = 0;
        m_kind = LK_NONE;
        m_head = 0;
        m_recs = 0;
        m_oldr = 0;
        m_newr = 0;
    endfunction

    function automatic logic [1:0] check_rows(int unsigned n, int unsigned hd, int unsigned cnt,
                                              int unsigned oldr, int unsigned newr,
                                              logic [2:0] kind);
        int unsigned tot;
        if (cnt > (65533 - hd) / oldr)
            return ST_BAD;
        if (n == hd + cnt * newr)
            return ST_SAME;
        if (n != hd + cnt * oldr)
            return ST_BAD;
        tot = hd + cnt * newr;
        if (fit_code(tot) != ST_CONV)
            return ST_CAP;
        m_kind = kind;
        m_head = hd;
        m_recs = cnt;
        m_oldr = oldr;
        m_newr = newr;
        m_len  = tot;
        return ST_CONV;
    endfunction

    function automatic logic [1:0] classify_packet();
        int unsigned n, op, hd, oldr, newr, sub, olds, extra;
        n    = m_cnt;
        hd   = 1;
        oldr = 0;
        newr = 0;
        if (m_ovf || n == 0 || n > 65533)
            return ST_BAD;
        op = fetch(0);
        if (op == OP_ROWS_A || op == OP_ROWS_B)
        begin
            hd   = (op == OP_ROWS_A) ? 5 : 3;
            oldr = (op == OP_ROWS_A) ? 28 : 30;
            if (n < hd)
                return ST_BAD;
            return check_rows(n, hd, fetch(hd - 2) | (fetch(hd - 1) << 8), oldr, oldr + 8,
                              LK_ROWS_FF);
        end
        if (op == OP_PLAIN || op == OP_TEXT)
        begin
            if (op == OP_TEXT)
            begin
                hd = string_end(n, 1);
                if (hd == 0)
                    return ST_BAD;
            end
            oldr = 12;
            newr = 13;
        end
        else if (op == OP_EXT)
        begin
            if (n < 3)
                return ST_BAD;
            sub   = fetch(1) | (fetch(2) << 8);
            hd    = 3;
            olds  = 0;
            extra = 0;
            if (sub == SUB_TAIL2)  begin olds = 23; extra = 2; end
            if (sub == SUB_TAIL1A) begin olds = 17; extra = 1; end
            if (sub == SUB_TAIL1B) begin olds = 22; extra = 1; end
            if (olds != 0)
            begin
                if (n == olds + extra)
                    return ST_SAME;
                if (n != olds)
                    return ST_BAD;
                if (fit_code(n + extra) != ST_CONV)
                    return ST_CAP;
                m_kind = LK_TAIL;
                m_len  = n + extra;
                return ST_CONV;
            end
            if (sub == SUB_INSERT)
            begin
                if (n >= 31 && (n - 31) % 16 == 0 && dword_at(27) == (n - 31) / 16)
                    return ST_SAME;
                if (n < 27 || (n - 27) % 16 != 0 || dword_at(23) != (n - 27) / 16)
                    return ST_BAD;
                if (fit_code(n + 4) != ST_CONV)
                    return ST_CAP;
                m_kind = LK_INSERT;
                m_len  = n + 4;
                return ST_CONV;
            end
            if (sub != SUB_ROWS)
                return ST_SAME;
            oldr = 16;
            newr = 20;
        end
        else if (op == OP_TRIPLE)
        begin
            hd = string_end(n, 21);
            if (hd == 0)
                return ST_BAD;
            if (n == hd + 52)
                return ST_SAME;
            if (n != hd + 40)
                return ST_BAD;
            if (fit_code(n + 12) != ST_CONV)
                return ST_CAP;
            m_kind = LK_TRIPLE;
            m_head = hd;
            m_len  = n + 12;
            return ST_CONV;
        end
        else
            return ST_SAME;
        if (n < hd + 4)
            return ST_BAD;
        return check_rows(n, hd + 4, dword_at(hd), oldr, newr, LK_ROWS_ZERO);
    endfunction

    function automatic int unsigned widened_byte(int unsigned i);
        int unsigned h, j, row, off;
        h = m_head;
        if (m_stat != ST_CONV || i >= m_len)
            return 0;
        case (m_kind)
            LK_ROWS_FF, LK_ROWS_ZERO:
            begin
                if (i < h)
                    return fetch(i);
                if (m_newr == 0)
                    return 0;
                j   = i - h;
                row = j / m_newr;
                off = j % m_newr;
                if (off < m_oldr)
                    return fetch(h + row * m_oldr + off);
                if (m_kind == LK_ROWS_FF && off - m_oldr >= 4)
                    return FILL_FF;
                return 0;
            end
            LK_TAIL:
                return (i < m_cnt) ? fetch(i) : 0;
            LK_INSERT:
            begin
                if (i < 19)
                    return fetch(i);
                if (i < 23)
                    return 0;
                return fetch(i - 4);
            end
            LK_TRIPLE:
            begin
                if (i < h + 28)
                    return fetch(i);
                j = i - (h + 28);
                if ((j & 7) >= 4)
                    return 0;
                return fetch(h + 28 + (j >> 3) * 4 + (j & 3));
            end
            default:
                return 0;
        endcase
    endfunction

    function automatic result_t predict_word(logic [1:0] fn, logic [7:0] db, logic [15:0] idx);
        result_t     r;
        logic [1:0]  s;
        int unsigned ob;
        ob = 0;
        case (fn)
            FN_CLEAR:
            begin
                m_cnt = 0;
                m_ovf = 1'b0;
                forget_layout();
            end
            FN_APPEND:
            begin
                if (m_cnt < BUFFER_BYTES)
                begin
                    pkt_mem[m_cnt] = db;
                    m_cnt++;
                end
                else
                    m_ovf = 1'b1;
                forget_layout();
            end
            FN_EVAL:
            begin
                forget_layout();
                s = classify_packet();
                if (s != ST_CONV)
                    forget_layout();
                m_stat = s;
            end
            default:
                ob = widened_byte(idx);
        endcase
        r.st  = m_stat;
        r.len = (m_stat == ST_CONV) ? m_len[15:0] : 16'd0;
        r.ob  = ob[7:0];
        return r;
    endfunction

    // ---------------- stimulus building ----------------

    function automatic void push_word(logic [1:0] fn, logic [7:0] db, logic [15:0] idx,
                                      bit fast = 1'b0);
        stim_t w;
        w.is_cfg = 1'b0;
        w.fast   = fast;
        w.fn     = fn;
        w.db     = db;
        w.idx    = idx;
        w.cfgv   = '0;
        pending_words.push_back(w);
    endfunction

    function automatic void push_cfg(logic [15:0] v);
        stim_t w;
        w.is_cfg = 1'b1;
        w.fast   = 1'b0;
        w.fn     = FN_CLEAR;
        w.db     = '0;
        w.idx    = '0;
        w.cfgv   = v;
        pending_words.push_back(w);
    endfunction

    function automatic logic [7:0] rnd8();
        return 8'($urandom);
    endfunction

    function automatic void add_rand(ref logic [7:0] p[$], input int unsigned n);
        repeat (n) p.push_back(rnd8());
    endfunction

    function automatic void add_le(ref logic [7:0] p[$], input int unsigned v, int unsigned nb);
        for (int k = 0; k < nb; k++)
            p.push_back(8'(v >> (8 * k)));
    endfunction

    // UTF-16 text of some non-zero pairs, closed by a double zero
    function automatic void add_text(ref logic [7:0] p[$]);
        logic [7:0] a, b;
        repeat ($urandom_range(0, 3))
        begin
            a = rnd8();
            b = rnd8();
            if (a == 0 && b == 0)
                a = 8'h41;
            p.push_back(a);
            p.push_back(b);
        end
        p.push_back(8'h00);
        p.push_back(8'h00);
    endfunction

    // clear, load one packet, evaluate, then read back a few bytes
    function automatic void make_packet(int kind, bit newform, bit mangle);
        logic [7:0]  p[$];
        logic [7:0]  op;
        int unsigned c, est, cpos, olds, extra, sub;
        c    = $urandom_range(0, 3);
        cpos = 0;
        est  = 0;
        case (kind)
            0:
            begin
                p = '{OP_ROWS_A, rnd8(), rnd8()};
                add_le(p, c, 2);
                cpos = 4;
                add_rand(p, c * (newform ? 36 : 28));
                est = 5 + 36 * c;
            end
            1:
            begin
                p = '{OP_ROWS_B};
                add_le(p, c, 2);
                cpos = 2;
                add_rand(p, c * (newform ? 38 : 30));
                est = 3 + 38 * c;
            end
            2, 3:
            begin
                p = '{(kind == 2) ? OP_PLAIN : OP_TEXT};
                if (kind == 3)
                    add_text(p);
                add_le(p, c, 4);
                cpos = p.size() - 1;
                add_rand(p, c * (newform ? 13 : 12));
                est = p.size() + 13 * c;
            end
            4:
            begin
                p = '{OP_EXT, SUB_ROWS[7:0], SUB_ROWS[15:8]};
                add_le(p, c, 4);
                cpos = 6;
                add_rand(p, c * (newform ? 20 : 16));
                est = 7 + 20 * c;
            end
            5:
            begin
                case ($urandom_range(0, 2))
                    0:       begin sub = SUB_TAIL2;  olds = 23; extra = 2; end
                    1:       begin sub = SUB_TAIL1A; olds = 17; extra = 1; end
                    default: begin sub = SUB_TAIL1B; olds = 22; extra = 1; end
                endcase
                p = '{OP_EXT, 8'(sub), 8'h00};
                add_rand(p, olds - 3 + (newform ? extra : 0));
                est = olds + extra;
            end
            6:
            begin
                p = '{OP_EXT, SUB_INSERT[7:0], SUB_INSERT[15:8]};
                add_rand(p, newform ? 24 : 20);
                add_le(p, c, 4);
                cpos = p.size() - 1;
                add_rand(p, 16 * c);
                est = 31 + 16 * c;
            end
            7:
            begin
                p = '{OP_TRIPLE};
                add_rand(p, 20);
                add_text(p);
                est = p.size() + 52;
                add_rand(p, newform ? 52 : 40);
            end
            default:
            begin
                if ($urandom_range(0, 1))
                begin
                    p   = '{OP_EXT};
                    sub = $urandom_range(0, 65535);
                    if (sub >= SUB_TAIL2 && sub <= SUB_INSERT)
                        sub = 16'hffff;
                    add_le(p, sub, 2);
                end
                else
                begin
                    op = rnd8();
                    if (op == OP_ROWS_A || op == OP_ROWS_B || op == OP_PLAIN || op == OP_TEXT ||
                        op == OP_EXT || op == OP_TRIPLE)
                        op = 8'h00;
                    p = '{op};
                end
                add_rand(p, $urandom_range(0, 8));
                est = p.size();
            end
        endcase
        if (mangle)
        begin
            case ($urandom_range(0, 3))
                0: if (p.size() > 1) void'(p.pop_back());
                1: p.push_back(rnd8());
                2: p[$urandom_range(0, p.size() - 1)] = rnd8();
                default:
                begin
                    // too many records, or a text cut short
                    if (cpos != 0)
                        p[cpos] = 8'hff;
                    else
                        p[$urandom_range(0, p.size() - 1)] = 8'h00;
                end
            endcase
        end
        push_word(FN_CLEAR, rnd8(), 16'($urandom));
        foreach (p[k])
            push_word(FN_APPEND, p[k], 16'($urandom));
        push_word(FN_EVAL, rnd8(), 16'($urandom));
        repeat ($urandom_range(1, 6))
        begin
            if ($urandom_range(0, 7) == 0)
                push_word(FN_READ, rnd8(), 16'($urandom));
            else
                push_word(FN_READ, rnd8(), 16'($urandom_range(0, est + 3)));
        end
    endfunction

    function automatic logic [15:0] pick_capacity();
        case ($urandom_range(0, 4))
            0:       return 16'd0;
            1:       return 16'd65535;
            2:       return 16'd65533;
            3:       return 16'($urandom_range(0, 300));
            default: return 16'($urandom);
        endcase
    endfunction

    // ---------------- driver ----------------

    int unsigned send_gap;
    int unsigned settle;

    always @(negedge clk or negedge rst_n)
    begin
        stim_t       w;
        logic        v;
        logic        cw;
        logic        fm;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            func        <= FN_CLEAR;
            data_byte   <= '0;
            out_index   <= '0;
            cfg_wr_en   <= 1'b0;
            cfg_wr_data <= '0;
            burst_mode  <= 1'b0;
            send_gap    = 0;
            settle      = 0;
        end
        else
        begin
            v  = in_valid;
            cw = 1'b0;
            fm = burst_mode;
            if (v && n_acc == n_issued)
                v = 1'b0;
            if (!v && n_acc == n_issued && expected_results.size() == 0)
                settle++;
            else
                settle = 0;
            if (!v)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_words.size() > 0)
                begin
                    w = pending_words[0];
                    if (w.is_cfg)
                    begin
                        // write only once the block has gone quiet
                        if (settle >= 10)
                        begin
                            void'(pending_words.pop_front());
                            cw          = 1'b1;
                            cfg_wr_data <= w.cfgv;
                            m_cap       = w.cfgv;
                            settle      = 0;
                        end
                    end
                    else
                    begin
                        void'(pending_words.pop_front());
                        v         = 1'b1;
                        func      <= w.fn;
                        data_byte <= w.db;
                        out_index <= w.idx;
                        n_issued++;
                        fm        = w.fast;
                        if (w.fast || (n_issued / 100) % 4 == 0)
                            send_gap = 0;
                        else
                            send_gap = $urandom_range(0, 9);
                    end
                end
            end
            in_valid   <= v;
            cfg_wr_en  <= cw;
            burst_mode <= fm;
        end
    end

    // ---------------- receiver ----------------

    int unsigned rx_seen;
    int unsigned rx_gap;
    int unsigned hold_cnt;
    bit          hold_done;

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_seen   = 0;
            rx_gap    = 0;
            hold_cnt  = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (!hold_done && n_acc >= 400)
            begin
                // long stall: let the block fill up and block its input
                hold_done = 1'b1;
                hold_cnt  = 300;
            end
            if (rx_seen != n_out)
            begin
                rx_seen = n_out;
                if (burst_mode || (n_out / 100) % 4 == 1)
                    rx_gap = 0;
                else
                    rx_gap = $urandom_range(0, 9);
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_ready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ---------------- prediction and checking ----------------

    always @(posedge clk)
    begin
        result_t e;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_packet_record_widening_converter_core: FAIL");
            $finish;
        end
        else if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(predict_word(func, data_byte, out_index));
                n_acc++;
            end
            if (out_valid && out_ready)
            begin
                n_out++;
                if (expected_results.size() == 0)
                begin
                    $error("result word with nothing expected");
                    n_fail++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (status !== e.st)
                    begin
                        $error("status expected %0d got %0d", e.st, status);
                        n_fail++;
                    end
                    if (out_length !== e.len)
                    begin
                        $error("out_length expected %0d got %0d", e.len, out_length);
                        n_fail++;
                    end
                    if (out_byte !== e.ob)
                    begin
                        $error("out_byte expected %0h got %0h", e.ob, out_byte);
                        n_fail++;
                    end
                end
            end
        end
    end

    // ---------------- sequence ----------------

    initial
    begin
        int unsigned words;
        n_issued = 0;
        n_acc    = 0;
        n_out    = 0;
        n_fail   = 0;
        cycles   = 0;
        m_cap    = 65535;
        m_cnt    = 0;
        m_ovf    = 1'b0;
        forget_layout();
        for (int k = 0; k < BUFFER_BYTES; k++)
            pkt_mem[k] = 8'h00;

        // directed part
        push_cfg(16'd65535);
        push_word(FN_EVAL, 8'hff, 16'hffff);
        push_word(FN_READ, 8'h00, 16'h0000);
        push_word(FN_CLEAR, 8'hff, 16'hffff);
        push_word(FN_EVAL, 8'h00, 16'h0000);
        for (int k = 0; k <= 8; k++)
            make_packet(k, 1'b0, 1'b0);
        make_packet(0, 1'b1, 1'b0);
        make_packet(6, 1'b1, 1'b0);
        make_packet(3, 1'b0, 1'b1);
        push_cfg(16'd8);
        make_packet(1, 1'b0, 1'b0);
        make_packet(5, 1'b0, 1'b0);
        push_cfg(16'd0);
        make_packet(7, 1'b0, 1'b0);
        push_cfg(16'd65535);

        // length above the limit, then an append past the end of the store
        push_word(FN_CLEAR, 8'h00, 16'h0000, 1'b1);
        for (int k = 0; k < 65534; k++)
            push_word(FN_APPEND, rnd8(), 16'h0000, 1'b1);
        push_word(FN_EVAL, 8'h00, 16'h0000, 1'b1);
        push_word(FN_READ, 8'h00, 16'd100, 1'b1);
        repeat (3) push_word(FN_APPEND, rnd8(), 16'h0000, 1'b1);
        push_word(FN_EVAL, 8'h00, 16'h0000, 1'b1);
        push_word(FN_CLEAR, 8'h00, 16'h0000, 1'b1);
        push_word(FN_EVAL, 8'h00, 16'h0000, 1'b1);

        // random part
        words = 0;
        while (words < 1500)
        begin
            if ($urandom_range(0, 39) == 0)
                push_cfg(pick_capacity());
            if ($urandom_range(0, 9) == 0)
            begin
                push_word(2'($urandom), rnd8(), 16'($urandom));
                words++;
            end
            else
            begin
                words += pending_words.size();
                make_packet($urandom_range(0, 8), $urandom_range(0, 4) == 0,
                            $urandom_range(0, 4) == 0);
                words -= pending_words.size();
                words = 0 - words;
            end
        end
        push_cfg(16'd65535);
        make_packet(0, 1'b0, 1'b0);

        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n = 1'b1;

        wait (pending_words.size() == 0 && n_acc == n_issued && !in_valid &&
              expected_results.size() == 0);
        repeat (40) @(posedge clk);
        if (n_fail == 0 && expected_results.size() == 0)
            $display("tb_packet_record_widening_converter_core: PASS");
        else
            $display("tb_packet_record_widening_converter_core: FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/prwc_pkg.sv
rtl/core/packet_record_widening_converter_core.sv
tb/tb_packet_record_widening_converter_core.sv
